FILE: hw/rtl/cbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbl_pkg;

  localparam int SCREEN_WIDTH = 320;

  localparam int X_W    = 9;
  localparam int Y_W    = 8;
  localparam int ADDR_W = 16;
  localparam int MASK_W = 8;
  localparam int ERR_W  = 11;

  localparam logic [ADDR_W-1:0] BASE_RESET = 16'h6000;
  localparam logic [MASK_W-1:0] LEFT_MASK  = 8'h80;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    logic [Y_W-1:0] y1;
    logic [X_W-1:0] x1;
    logic [Y_W-1:0] y0;
    logic [X_W-1:0] x0;
  } line_req_t;

  typedef struct packed {
    logic              last;
    logic [MASK_W-1:0] mask;
    logic [ADDR_W-1:0] addr;
  } pixel_t;

  // Cell layout: eight rows per character row, eight bytes per cell column.
  function automatic logic [ADDR_W-1:0] pixel_addr(input logic [ADDR_W-1:0] base,
                                                   input logic [X_W-1:0]    x,
                                                   input logic [Y_W-1:0]    y);
    logic [ADDR_W-1:0] row_off;
    row_off = ADDR_W'(y[Y_W-1:3]) * ADDR_W'(SCREEN_WIDTH);
    return base + row_off + ADDR_W'({x[X_W-1:3], 3'b000}) + ADDR_W'(y[2:0]);
  endfunction

  function automatic logic [MASK_W-1:0] pixel_mask(input logic [X_W-1:0] x);
    return LEFT_MASK >> x[2:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cell_bitmap_line_plotter.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: operation; tdata: endpoints
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: address, mask; tlast: last
// cfg       in   cfg_valid / cfg_ready          cfg_data: bitmap base address
//
// One beat per clock in while s_axis_tready is high. A step beat's pixel out is
// registered; the address is a constant multiply and four-term add of the line state.
// A start beat loads the line state and gives no output beat.
// A two-entry output buffer takes one more beat while m_axis stalls, then drops
// s_axis_tready until the stall clears.
// Reset idles the line, sets the bitmap base to 0x6000 and holds both readys low.
`timescale 1ns / 1ps
`default_nettype none

module cell_bitmap_line_plotter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // start_x[8:0], start_y[16:9], end_x[25:17],
                                          // end_y[33:26], zero fill[39:34]
  input  wire logic        s_axis_tuser,  // operation[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // byte_address[15:0], bit_mask[23:16]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import cbl_pkg::*;

  logic              s_fire;
  op_t               op;
  line_req_t         req;
  logic [ADDR_W-1:0] bitmap_base;
  logic              emit;
  pixel_t            step_pix;
  pixel_t            out_pix;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign op        = op_t'(s_axis_tuser);
  assign req       = line_req_t'(s_axis_tdata[33:0]);
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap_base <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bitmap_base <= cfg_data;
    end
  end

  cbl_stepper u_stepper (
    .clk  (clk),
    .rst  (rst),
    .fire (s_fire),
    .op   (op),
    .req  (req),
    .base (bitmap_base),
    .emit (emit),
    .pix  (step_pix)
  );

  cbl_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_pix  (step_pix),
    .ready     (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pix   (out_pix)
  );

  assign m_axis_tdata = {out_pix.mask, out_pix.addr};
  assign m_axis_tlast = out_pix.last;

endmodule

`default_nettype wire

FILE: hw/rtl/cbl_stepper.sv
`timescale 1ns / 1ps
`default_nettype none

module cbl_stepper (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      fire,
  input  wire cbl_pkg::op_t              op,
  input  wire cbl_pkg::line_req_t        req,
  input  wire logic [cbl_pkg::ADDR_W-1:0] base,
  output logic                           emit,
  output cbl_pkg::pixel_t                pix
);
  import cbl_pkg::*;

  logic             line_active;
  logic [X_W-1:0]   cur_x;
  logic [Y_W-1:0]   cur_y;
  logic [X_W-1:0]   target_x;
  logic [Y_W-1:0]   target_y;
  logic [X_W-1:0]   delta_x;
  logic [X_W-1:0]   neg_delta_y;
  logic [1:0]       step_dirs;
  logic [ERR_W-1:0] error_term;

  logic [X_W-1:0]   dx_start;
  logic [Y_W-1:0]   dy_start;
  logic [X_W-1:0]   ndy_start;
  logic [ERR_W-1:0] err_start;

  logic [ERR_W:0]   e2;
  logic [ERR_W:0]   ndy_ext;
  logic [ERR_W:0]   dx_ext;
  logic             take_x;
  logic             take_y;
  logic             at_end;
  logic [ERR_W-1:0] error_next;
  logic [X_W-1:0]   cur_x_next;
  logic [Y_W-1:0]   cur_y_next;

  always_comb begin
    dx_start  = (req.x1 >= req.x0) ? req.x1 - req.x0 : req.x0 - req.x1;
    dy_start  = (req.y1 >= req.y0) ? req.y1 - req.y0 : req.y0 - req.y1;
    ndy_start = X_W'(0) - {1'b0, dy_start};
    err_start = ERR_W'(dx_start) + {{(ERR_W-X_W){ndy_start[X_W-1]}}, ndy_start};
  end

  always_comb begin
    e2      = {error_term, 1'b0};
    ndy_ext = {{(ERR_W+1-X_W){neg_delta_y[X_W-1]}}, neg_delta_y};
    dx_ext  = (ERR_W+1)'(delta_x);
    take_x  = $signed(e2) >= $signed(ndy_ext);
    take_y  = $signed(e2) <= $signed(dx_ext);
    at_end  = (cur_x == target_x) && (cur_y == target_y);

    error_next = error_term
               + (take_x ? ndy_ext[ERR_W-1:0] : ERR_W'(0))
               + (take_y ? dx_ext[ERR_W-1:0] : ERR_W'(0));
    cur_x_next = cur_x;
    if (take_x) begin
      cur_x_next = step_dirs[0] ? cur_x + X_W'(1) : cur_x - X_W'(1);
    end
    cur_y_next = cur_y;
    if (take_y) begin
      cur_y_next = step_dirs[1] ? cur_y + Y_W'(1) : cur_y - Y_W'(1);
    end

    emit     = fire && (op == OP_STEP) && line_active;
    pix.addr = pixel_addr(base, cur_x, cur_y);
    pix.mask = pixel_mask(cur_x);
    pix.last = at_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      target_x    <= '0;
      target_y    <= '0;
      delta_x     <= '0;
      neg_delta_y <= '0;
      step_dirs   <= '0;
      error_term  <= '0;
    end else if (fire && (op == OP_START)) begin
      // load endpoints; any line in progress is dropped
      line_active <= 1'b1;
      cur_x       <= req.x0;
      cur_y       <= req.y0;
      target_x    <= req.x1;
      target_y    <= req.y1;
      delta_x     <= dx_start;
      neg_delta_y <= ndy_start;
      step_dirs   <= {req.y0 < req.y1, req.x0 < req.x1};
      error_term  <= err_start;
    end else if (emit) begin
      if (at_end) begin
        line_active <= 1'b0;
      end else begin
        cur_x      <= cur_x_next;
        cur_y      <= cur_y_next;
        error_term <= error_next;
      end
    end
  end

  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && pix.last) |=> !line_active)
    else $error("line still active after its last pixel");

  a_mask_onehot: assert property (@(posedge clk) disable iff (rst)
    emit |-> $onehot(pix.mask))
    else $error("pixel mask not one-hot");

  a_step_moves: assert property (@(posedge clk) disable iff (rst)
    (emit && !pix.last) |=> ((cur_x != $past(cur_x)) || (cur_y != $past(cur_y))))
    else $error("step left the pixel position unchanged");

endmodule

`default_nettype wire

FILE: hw/rtl/cbl_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module cbl_out_buf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire cbl_pkg::pixel_t push_pix,
  output logic                 ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cbl_pkg::pixel_t      out_pix
);
  import cbl_pkg::*;

  logic   main_valid;
  pixel_t main_pix;
  logic   skid_valid;
  pixel_t skid_pix;

  // hold off new beats during reset so none is taken and then dropped
  assign ready     = !skid_valid && !rst;
  assign out_valid = main_valid;
  assign out_pix   = main_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      // output slot frees up: refill from skid first, else from the new beat
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_pix <= skid_valid ? skid_pix : push_pix;
    end else if (push) begin
      skid_pix <= push_pix;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid holds a beat while output is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("beat pushed into full buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (main_valid && !skid_valid))
    else $error("skid beat not moved forward");

endmodule

`default_nettype wire

FILE: bench/cell_bitmap_line_plotter_test.sv
`timescale 1ns / 1ps

module cell_bitmap_line_plotter_test;
  import cbl_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // start_x[8:0], start_y[16:9], end_x[25:17],
                                   // end_y[33:26], zero fill[39:34]
  logic        s_axis_tuser = 1'b0;  // operation[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // byte_address[15:0], bit_mask[23:16]
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  cell_bitmap_line_plotter dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Line tracer state, mirrors what the plotter holds.
  logic [ADDR_W-1:0] base_addr = BASE_RESET;
  logic              line_on = 1'b0;
  logic [X_W-1:0]    pen_x = '0, goal_x = '0;
  logic [Y_W-1:0]    pen_y = '0, goal_y = '0;
  logic              x_up = 1'b0, y_up = 1'b0;
  int                run_x = 0, rise_neg = 0, bres_err = 0;

  pixel_t      pending_pixels[$];
  int          error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  // Work out the pixel (if any) that one accepted beat produces.
  task automatic trace_pixel(input op_t op, input logic [X_W-1:0] x0, input logic [Y_W-1:0] y0,
                             input logic [X_W-1:0] x1, input logic [Y_W-1:0] y1);
    pixel_t px;
    int     e2;
    int     offs;
    if (op == OP_START) begin
      pen_x    = x0;
      pen_y    = y0;
      goal_x   = x1;
      goal_y   = y1;
      run_x    = (x1 >= x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
      rise_neg = (y1 >= y0) ? int'(y0) - int'(y1) : int'(y1) - int'(y0);
      x_up     = x0 < x1;
      y_up     = y0 < y1;
      bres_err = run_x + rise_neg;
      line_on  = 1'b1;
    end else if (line_on) begin
      offs = int'(base_addr) + int'(pen_y >> 3) * SCREEN_WIDTH + int'({pen_x[X_W-1:3], 3'b000})
             + int'(pen_y[2:0]);
      px.addr = offs[ADDR_W-1:0];
      px.mask = LEFT_MASK >> pen_x[2:0];
      px.last = (pen_x == goal_x) && (pen_y == goal_y);
      pending_pixels.push_back(px);
      if (px.last) begin
        line_on = 1'b0;
      end else begin
        e2 = 2 * bres_err;
        if (e2 >= rise_neg) begin
          bres_err += rise_neg;
          pen_x = x_up ? pen_x + 1'b1 : pen_x - 1'b1;
        end
        if (e2 <= run_x) begin
          bres_err += run_x;
          pen_y = y_up ? pen_y + 1'b1 : pen_y - 1'b1;
        end
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(input op_t op, input logic [X_W-1:0] x0, input logic [Y_W-1:0] y0,
                           input logic [X_W-1:0] x1, input logic [Y_W-1:0] y1);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tuser  <= 1'($urandom_range(1));
      s_axis_tdata  <= {6'b0, 34'({$urandom, $urandom})};
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, y1, x1, y0, x0};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    trace_pixel(op, x0, y0, x1, y1);
    @(negedge clk);
  endtask

  task automatic send_step();
    send_item(OP_STEP, X_W'($urandom_range(511)), Y_W'($urandom_range(255)),
              X_W'($urandom_range(511)), Y_W'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    // hold off until a pending start or buffered beat has settled
    repeat (4) @(negedge clk);
  endtask

  task automatic write_base(input logic [ADDR_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    base_addr = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= 16'($urandom);
  endtask

  task automatic draw_whole_line(input logic [X_W-1:0] x0, input logic [Y_W-1:0] y0,
                                 input logic [X_W-1:0] x1, input logic [Y_W-1:0] y1);
    send_item(OP_START, x0, y0, x1, y1);
    while (line_on) send_step();
  endtask

  task automatic test_idle_steps_and_reset_base();
    send_step();
    send_step();
    draw_whole_line(9'd0, 8'd0, 9'd0, 8'd0);
    send_step();
  endtask

  task automatic test_base_extremes();
    write_base(16'h0000);
    draw_whole_line(9'd0, 8'd0, 9'd0, 8'd0);
    write_base(16'hFFFF);
    draw_whole_line(9'd511, 8'd255, 9'd511, 8'd255);
    draw_whole_line(9'd319, 8'd199, 9'd318, 8'd199);
  endtask

  task automatic test_octants();
    draw_whole_line(9'd10, 8'd10, 9'd12, 8'd11);  // shallow, right and down
    draw_whole_line(9'd21, 8'd22, 9'd20, 8'd20);  // steep, left and up
    draw_whole_line(9'd30, 8'd22, 9'd31, 8'd20);  // steep, right and up
    draw_whole_line(9'd42, 8'd20, 9'd40, 8'd21);  // shallow, left and down
  endtask

  task automatic test_line_replace();
    send_item(OP_START, 9'd100, 8'd50, 9'd110, 8'd60);
    repeat (3) send_step();
    draw_whole_line(9'd5, 8'd5, 9'd5, 8'd7);
    send_step();
  endtask

  function automatic int clip(input int v, input int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  task automatic test_random_lines(input int n_items, input int unsigned idle,
                                   input int unsigned stall, input logic [ADDR_W-1:0] base);
    int count;
    int pick;
    int cap;
    int extra;
    int x0, y0, x1, y1;
    write_base(base);
    send_idle_pct = idle;
    stall_pct     = stall;
    count = 0;
    while (count < n_items) begin
      x0   = $urandom_range(511);
      y0   = $urandom_range(255);
      pick = $urandom_range(99);
      if (pick < 3) begin
        x1 = $urandom_range(511);
        y1 = $urandom_range(255);
      end else if (pick < 8) begin
        x1 = x0;
        y1 = y0;
      end else if (pick < 16) begin
        x1 = clip(x0 + int'($urandom_range(24)) - 12, 511);
        y1 = y0;
      end else if (pick < 24) begin
        x1 = x0;
        y1 = clip(y0 + int'($urandom_range(24)) - 12, 255);
      end else begin
        x1 = clip(x0 + int'($urandom_range(24)) - 12, 511);
        y1 = clip(y0 + int'($urandom_range(24)) - 12, 255);
      end
      send_item(OP_START, X_W'(x0), Y_W'(y0), X_W'(x1), Y_W'(y1));
      count++;
      // most lines run to the end; some get cut short, some get stray steps after
      pick  = $urandom_range(99);
      cap   = (pick < 10) ? $urandom_range(6) : 1 << 20;
      extra = (pick >= 10 && pick < 20) ? $urandom_range(1, 3) : 0;
      while (cap > 0 && (line_on || extra > 0)) begin
        if (!line_on) extra--;
        send_step();
        count++;
        cap--;
      end
    end
  endtask

  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel beat: byte_address %h bit_mask %h last %b",
               m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tlast);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata[15:0] !== want.addr) begin
          $error("byte_address: expected %h, got %h", want.addr, m_axis_tdata[15:0]);
          error_count++;
        end
        if (m_axis_tdata[23:16] !== want.mask) begin
          $error("bit_mask: expected %h, got %h", want.mask, m_axis_tdata[23:16]);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_idle_steps_and_reset_base();
    test_base_extremes();
    test_octants();
    test_line_replace();
    test_random_lines(400, 0, 0, 16'h6000);
    test_random_lines(400, 71, 0, 16'($urandom));
    test_random_lines(400, 0, 71, 16'hFFFF);
    test_random_lines(400, 8, 8, 16'h0000);
    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
